@@ rtl/core/utf8_to_utf16_decoder_defines.svh @@
// Shared assertion macros for the UTF-8 to UTF-16 decoder checkers.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utd assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define UTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utd assertion failed");

`endif

@@ rtl/core/utd_pkg.sv @@
package utd_pkg;

  localparam logic [15:0] UNIT_BAD    = 16'h003F;
  localparam logic [15:0] HI_BASE     = 16'hD800;
  localparam logic [15:0] LO_BASE     = 16'hDC00;
  localparam logic [25:0] PAIR_OFFSET = 26'h0010000;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ONE     = 2'd1,
    KIND_PAIR    = 2'd2,
    KIND_SWALLOW = 2'd3
  } seq_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
  } out_word_t;

endpackage

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// Channel  Ports                                   Word
// in       in_valid / in_ready / in_data           in_word_t  (one UTF-8 byte)
// out      out_valid / out_ready / out_data        out_word_t (one UTF-16 unit)
// cfg      cfg_wr_en / cfg_wr_data                 16-bit unit limit
//
// A byte is decoded in the cycle it is accepted; its zero, one or two units
// land in a four-word result queue and leave one per cycle from the next
// cycle while out_ready is high. One byte per cycle while the queue has room
// for two words; a byte that gives a surrogate pair puts two words in it.
// Synchronous active-low reset clears decode state and the queue, and sets the
// limit to 65535.
// A stalled output fills the queue; in_ready drops once it holds three words.
module utf8_to_utf16_decoder
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] unit_limit_r;
  logic [2:0]  pending_r, pending_nxt;
  logic [20:0] accum_r, accum_nxt;
  seq_kind_t   kind_r, kind_nxt;
  logic [16:0] emitted_r, emitted_nxt;

  out_word_t   fifo_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic        c0, c1, e0, e1;
  logic [15:0] u0, u1;
  logic [20:0] shifted;
  logic [25:0] pair_v;
  logic [16:0] emitted_1;
  logic [1:0]  n_push;
  out_word_t   w0, w1;

  assign in_ready  = (count_r <= 3'd2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_acc   = out_valid && out_ready;
  assign out_data  = fifo_r[rd_ptr_r];
  assign b         = in_data.in_byte;

  always_comb begin
    pending_nxt = pending_r;
    accum_nxt   = accum_r;
    kind_nxt    = kind_r;
    c0          = 1'b0;
    c1          = 1'b0;
    u0          = UNIT_BAD;
    u1          = UNIT_BAD;
    shifted     = {accum_r[14:0], b[5:0]};
    pair_v      = {5'd0, shifted} - PAIR_OFFSET;
    if (pending_r == 3'd0) begin
      unique casez (b)
        8'b0???????: begin
          c0 = 1'b1;
          u0 = {8'd0, b};
        end
        8'b10??????: c0 = 1'b1;
        8'b110?????: begin
          pending_nxt = 3'd1;
          accum_nxt   = {16'd0, b[4:0]};
          kind_nxt    = KIND_ONE;
        end
        8'b1110????: begin
          pending_nxt = 3'd2;
          accum_nxt   = {17'd0, b[3:0]};
          kind_nxt    = KIND_ONE;
        end
        8'b11110???: begin
          pending_nxt = 3'd3;
          accum_nxt   = {18'd0, b[2:0]};
          kind_nxt    = KIND_PAIR;
        end
        8'b111110??: begin
          c0          = 1'b1;
          pending_nxt = 3'd4;
          accum_nxt   = '0;
          kind_nxt    = KIND_SWALLOW;
        end
        8'b1111110?: begin
          c0          = 1'b1;
          pending_nxt = 3'd5;
          accum_nxt   = '0;
          kind_nxt    = KIND_SWALLOW;
        end
        default: c0 = 1'b1;
      endcase
    end else begin
      pending_nxt = pending_r - 3'd1;
      if (kind_r != KIND_SWALLOW) begin
        accum_nxt = shifted;
      end
      if (pending_nxt == 3'd0) begin
        case (kind_r)
          KIND_ONE: begin
            c0 = 1'b1;
            u0 = shifted[15:0];
          end
          KIND_PAIR: begin
            c0 = 1'b1;
            u0 = HI_BASE + pair_v[25:10];
            c1 = 1'b1;
            u1 = LO_BASE + {6'd0, pair_v[9:0]};
          end
          default: ;
        endcase
        kind_nxt  = KIND_NONE;
        accum_nxt = '0;
      end
    end
    if (in_data.end_of_string) begin
      if (pending_nxt != 3'd0 && kind_nxt != KIND_SWALLOW) begin
        c0 = 1'b1;
        u0 = UNIT_BAD;
      end
      pending_nxt = 3'd0;
      accum_nxt   = '0;
      kind_nxt    = KIND_NONE;
    end
  end

  always_comb begin
    e0          = c0 && (emitted_r < {1'b0, unit_limit_r});
    emitted_1   = emitted_r + {16'd0, e0};
    e1          = c1 && (emitted_1 < {1'b0, unit_limit_r});
    emitted_nxt = in_data.end_of_string ? 17'd0 : emitted_1 + {16'd0, e1};
    n_push      = {1'b0, e0} + {1'b0, e1};
    w0.code_unit = e0 ? u0 : u1;
    w0.run_end   = !(e0 && e1);
    w1.code_unit = u1;
    w1.run_end   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_limit_r <= LIMIT_RESET;
      pending_r    <= '0;
      accum_r      <= '0;
      kind_r       <= KIND_NONE;
      emitted_r    <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unit_limit_r <= cfg_wr_data;
      end
      if (in_acc) begin
        pending_r <= pending_nxt;
        accum_r   <= accum_nxt;
        kind_r    <= kind_nxt;
        emitted_r <= emitted_nxt;
        wr_ptr_r  <= wr_ptr_r + n_push;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + (in_acc ? {1'b0, n_push} : 3'd0) - {2'd0, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= w0;
    end
    if (in_acc && n_push == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= w1;
    end
  end

endmodule

@@ rtl/core/utd_checker.sv @@
`include "utf8_to_utf16_decoder_defines.svh"

module utd_checker
  import utd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_word_t   out_data
);

  logic out_acc;
  logic hi_open;

  assign out_acc = out_valid && out_ready;
  assign hi_open = out_acc && !out_data.run_end;

  `UTD_ASSERT_IMP(a_empty_ready, !out_valid, in_ready)
  `UTD_ASSERT_NXT(a_run_continues, hi_open, out_valid)
  `UTD_ASSERT_NXT(a_low_follows, hi_open, out_data.code_unit[15:10] == 6'b110111)
  `UTD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind utf8_to_utf16_decoder utd_checker u_utd_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import utd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  typedef logic [7:0] byte_list_t[$];

  // stimulus and expected units
  in_word_t  tx_words[$];
  out_word_t expected_units[$];

  // decoder state as predicted
  logic [15:0] unit_limit;
  logic [2:0]  pend;
  logic [20:0] accum;
  seq_kind_t   kind;
  logic [16:0] units_sent;
  out_word_t   step_units[0:2];
  int          step_n;

  out_word_t want;
  logic      in_took = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_left = 0;
  int        stall_asked = 0;
  int        stall_served = 0;
  logic      in_idle_on = 1'b1;
  logic      out_idle_on = 1'b1;
  int        errors = 0;
  int        bytes_taken = 0;
  int        bytes_queued = 0;
  int        units_checked = 0;
  int        strings_queued = 0;
  int        phases_run = 0;

  utf8_to_utf16_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(input logic idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void emit(input logic [15:0] u);
    if (units_sent < {1'b0, unit_limit}) begin
      step_units[step_n] = {u, 1'b0};
      step_n++;
      units_sent = units_sent + 17'd1;
    end
  endfunction

  task automatic decode_byte(input in_word_t w);
    logic [7:0]  b;
    logic [31:0] v;
    step_n = 0;
    b = w.in_byte;
    if (pend == 3'd0) begin
      if (b < 8'h80) begin
        emit({8'h00, b});
      end else if (b < 8'hC0) begin
        emit(UNIT_BAD);
      end else if (b < 8'hE0) begin
        pend = 3'd1; accum = {16'd0, b[4:0]}; kind = KIND_ONE;
      end else if (b < 8'hF0) begin
        pend = 3'd2; accum = {17'd0, b[3:0]}; kind = KIND_ONE;
      end else if (b < 8'hF8) begin
        pend = 3'd3; accum = {18'd0, b[2:0]}; kind = KIND_PAIR;
      end else if (b < 8'hFC) begin
        emit(UNIT_BAD);
        pend = 3'd4; accum = '0; kind = KIND_SWALLOW;
      end else if (b < 8'hFE) begin
        emit(UNIT_BAD);
        pend = 3'd5; accum = '0; kind = KIND_SWALLOW;
      end else begin
        emit(UNIT_BAD);
      end
    end else begin
      pend = pend - 3'd1;
      if (kind != KIND_SWALLOW) accum = {accum[14:0], b[5:0]};
      if (pend == 3'd0) begin
        if (kind == KIND_ONE) begin
          emit(accum[15:0]);
        end else if (kind == KIND_PAIR) begin
          v = {11'd0, accum} - 32'h0001_0000;
          emit(HI_BASE + v[25:10]);
          emit(LO_BASE + {6'd0, v[9:0]});
        end
        kind = KIND_NONE;
        accum = '0;
      end
    end
    if (w.end_of_string) begin
      if (pend != 3'd0 && kind != KIND_SWALLOW) emit(UNIT_BAD);
      pend = '0;
      accum = '0;
      kind = KIND_NONE;
      units_sent = '0;
    end
    if (step_n > 0) step_units[step_n - 1].run_end = 1'b1;
    for (int i = 0; i < step_n; i++) expected_units.insert(expected_units.size(), step_units[i]);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (tx_words.size() > 0) begin
        in_data <= tx_words.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap(in_idle_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_served != stall_asked) begin
        stall_served <= stall_asked;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap(out_idle_on);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
      unit_limit = LIMIT_RESET;
      pend = '0;
      accum = '0;
      kind = KIND_NONE;
      units_sent = '0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        decode_byte(in_data);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        units_checked++;
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h/%b",
                   $time, out_data.code_unit, out_data.run_end);
          errors++;
        end else begin
          want = expected_units.pop_front();
          if (out_data.code_unit !== want.code_unit) begin
            $display("%0t: code_unit mismatch, expected %h, actual %h",
                     $time, want.code_unit, out_data.code_unit);
            errors++;
          end
          if (out_data.run_end !== want.run_end) begin
            $display("%0t: run_end mismatch, expected %b, actual %b",
                     $time, want.run_end, out_data.run_end);
            errors++;
          end
        end
      end
      if (cfg_wr_en) unit_limit = cfg_wr_data;
    end
  end

  task automatic push_string(input byte_list_t s);
    for (int i = 0; i < s.size(); i++) begin
      tx_words.insert(tx_words.size(), {s[i], i == s.size() - 1});
    end
    bytes_queued += s.size();
    strings_queued++;
  endtask

  function automatic logic [7:0] follower();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic add_random_string(inout int count);
    byte_list_t s;
    int chars;
    int pick;
    int len;
    chars = $urandom_range(1, 8);
    for (int c = 0; c < chars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        s.insert(s.size(), 8'($urandom_range(0, 127)));
      end else if (pick < 45) begin
        s.insert(s.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        s.insert(s.size(), follower());
      end else if (pick < 65) begin
        s.insert(s.size(), 8'hE0 | 8'($urandom_range(0, 15)));
        repeat (2) s.insert(s.size(), follower());
      end else if (pick < 85) begin
        s.insert(s.size(), 8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) s.insert(s.size(), follower());
      end else if (pick < 95) begin
        s.insert(s.size(), 8'($urandom));
      end else if (pick < 98) begin
        s.insert(s.size(), 8'hF8 | 8'($urandom_range(0, 3)));
        repeat (4) s.insert(s.size(), follower());
      end else begin
        s.insert(s.size(), 8'hFC | 8'($urandom_range(0, 1)));
        repeat (5) s.insert(s.size(), follower());
      end
    end
    // cut some strings short, often in the middle of a sequence
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, s.size());
      while (s.size() > len) void'(s.pop_back());
    end
    count += s.size();
    push_string(s);
  endtask

  task automatic drain();
    @(negedge clk);
    while (bytes_taken != bytes_queued || expected_units.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] lim;
    int phase_bytes;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_limit(LIMIT_RESET);
    push_string('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF});
    push_string('{8'hC2, 8'hE9, 8'hE2, 8'h82, 8'hAC});
    push_string('{8'hF0, 8'h9F, 8'h98, 8'h80});
    push_string('{8'hF8, 8'h01, 8'h02, 8'h03, 8'h04, 8'h41});
    push_string('{8'hFC, 8'h80});
    push_string('{8'hE2, 8'h82});
    drain();

    for (int p = 0; p < 8; p++) begin
      in_idle_on = 1'b1;
      out_idle_on = 1'b1;
      case (p)
        0: lim = 16'hFFFF;
        1: lim = 16'h0000;
        2: lim = 16'h0001;
        3: lim = 16'h0002;
        4: begin
          lim = 16'hFFFF;
          in_idle_on = 1'b0;
          out_idle_on = 1'b0;
        end
        5: lim = 16'h0003;
        6: begin
          lim = 16'($urandom_range(4, 12));
          in_idle_on = 1'b0;
          out_idle_on = 1'b0;
        end
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      write_limit(lim);
      phase_bytes = 0;
      while (phase_bytes < 75) add_random_string(phase_bytes);
      // hold the receiver off so the result queue fills and input stalls
      if (p == 4) stall_asked++;
      drain();
      phases_run++;
    end

    $display("covered %0d bytes in %0d strings, %0d units checked over %0d limit settings",
             bytes_taken, strings_queued, units_checked, phases_run + 1);
    $display("including a long output stall with back-pressure and idle drains");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/utd_pkg.sv
rtl/core/utf8_to_utf16_decoder.sv
rtl/core/utd_checker.sv
bench/tb.sv
